// ----- rtl/lesf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_pkg: shared types, constants and helpers
// Sizes, widths, register indexes and the line buffer control bundle.
// ----------------------------------------------------------------------------
package lesf_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int SIZE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_POS_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES   = 1'b1;

  typedef logic [SIZE_W-1:0] size_t;

  // Line buffer control: advance the read chain, reload it from the stored row
  // at the end of a row, and the column that takes the new size
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [COL_W-1:0] col;
  } lb_ctrl_t;

  // Last column index for a register value: zero counts as one, clamp at the maximum
  function automatic logic [COL_W-1:0] last_col(input logic [CFG_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_COLUMNS) begin
      r = COL_W'(MAX_COLUMNS - 1);
    end else begin
      r = COL_W'(32'(v) - 1);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] last_row(input logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_ROWS) begin
      r = ROW_W'(MAX_ROWS - 1);
    end else begin
      r = ROW_W'(32'(v) - 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/lesf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_cell: one line buffer cell
// Keeps the last size written for its column, and one stage of the read
// chain that is reloaded from the stored sizes at the end of a row and
// otherwise takes its neighbor's value on every transfer.
// ----------------------------------------------------------------------------
module lesf_cell (
  input  logic                      clk,
  input  lesf_pkg::lb_ctrl_t        ctrl,
  input  logic [lesf_pkg::COL_W-1:0] cell_idx,
  input  lesf_pkg::size_t           nbr_val,
  input  lesf_pkg::size_t           ins_val,
  output lesf_pkg::size_t           val
);

  lesf_pkg::size_t stored_r;
  lesf_pkg::size_t val_r;
  logic            hit;

  assign hit = ctrl.shift && (ctrl.col == cell_idx);

  always_ff @(posedge clk) begin
    if (hit) begin
      stored_r <= ins_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      if (ctrl.load) begin
        val_r <= hit ? ins_val : stored_r;
      end else begin
        val_r <= nbr_val;
      end
    end
  end

  assign val = val_r;

endmodule

// ----- rtl/lesf_line_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_line_buf: previous row as a chain of cells
// Each cell stores the size last written for its column. At the end of a row
// the read chain loads those sizes, then moves one cell toward the head per
// transfer, so the head holds the size above the current column.
// ----------------------------------------------------------------------------
module lesf_line_buf (
  input  logic               clk,
  input  lesf_pkg::lb_ctrl_t ctrl,
  input  lesf_pkg::size_t    ins_val,
  output lesf_pkg::size_t    above
);

  lesf_pkg::size_t chain [lesf_pkg::MAX_COLUMNS];

  for (genvar i = 0; i < lesf_pkg::MAX_COLUMNS; i++) begin : g_cell
    lesf_pkg::size_t nbr;
    if (i == lesf_pkg::MAX_COLUMNS - 1) begin : g_end
      assign nbr = ins_val;
    end else begin : g_mid
      assign nbr = chain[i+1];
    end

    lesf_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (lesf_pkg::COL_W'(i)),
      .nbr_val  (nbr),
      .ins_val  (ins_val),
      .val      (chain[i])
    );
  end

  assign above = chain[0];

endmodule

// ----- rtl/largest_empty_square_finder_core.sv -----
`timescale 1ns / 1ps
// Throughput: one cell per cycle when the skid is empty. The line buffer chain advances
// on every transfer; each result goes to the output register, or the skid on a stall.
// A two-entry output stage (register plus skid) keeps input flowing under stalls.
// Reset (rst_n low, synchronous) empties the output stage, restarts the map and
// sets both size registers to 1024; line buffer contents are not cleared.
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core: streamed maximal empty square search
// Computes per-cell square sizes in scan order and reports the best square
// on the last cell of each map.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cell_empty,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lesf_pkg::SIZE_W-1:0]        out_cell_size,
  output logic                               out_map_done,
  output logic [lesf_pkg::OUT_POS_W-1:0]     out_best_row,
  output logic [lesf_pkg::OUT_POS_W-1:0]     out_best_col,
  output logic [lesf_pkg::SIZE_W-1:0]        out_best_size
);

  typedef struct packed {
    logic [lesf_pkg::SIZE_W-1:0]    cell_size;
    logic                           map_done;
    logic [lesf_pkg::OUT_POS_W-1:0] best_row;
    logic [lesf_pkg::OUT_POS_W-1:0] best_col;
    logic [lesf_pkg::SIZE_W-1:0]    best_size;
  } res_t;

  logic [lesf_pkg::COL_W-1:0] last_col_r;
  logic [lesf_pkg::ROW_W-1:0] last_row_r;
  logic [lesf_pkg::COL_W-1:0] col_pos_r;
  logic [lesf_pkg::ROW_W-1:0] row_pos_r;
  lesf_pkg::size_t            left_r;
  lesf_pkg::size_t            diag_r;
  lesf_pkg::size_t            best_size_r;
  logic [lesf_pkg::ROW_W-1:0] best_row_r;
  logic [lesf_pkg::COL_W-1:0] best_col_r;

  lesf_pkg::size_t            best_size_nxt;
  logic [lesf_pkg::ROW_W-1:0] best_row_nxt;
  logic [lesf_pkg::COL_W-1:0] best_col_nxt;

  res_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;

  logic                  fire_in, out_pop, row_end, done;
  lesf_pkg::size_t       above, min_ul, min3, size;
  logic [lesf_pkg::SIZE_W:0] inc;
  lesf_pkg::lb_ctrl_t    lb_ctrl;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= lesf_pkg::COL_W'(lesf_pkg::MAX_COLUMNS - 1);
      last_row_r <= lesf_pkg::ROW_W'(lesf_pkg::MAX_ROWS - 1);
    end else if (cfg_valid) begin
      case (cfg_index)
        lesf_pkg::REG_COLUMNS: last_col_r <= lesf_pkg::last_col(cfg_data);
        lesf_pkg::REG_LINES:   last_row_r <= lesf_pkg::last_row(cfg_data);
        default: ;
      endcase
    end
  end

  // Line buffer: store the size at the current column, reload the read chain at row end
  assign lb_ctrl.shift = fire_in;
  assign lb_ctrl.load  = row_end;
  assign lb_ctrl.col   = col_pos_r;

  lesf_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .ins_val (size),
    .above   (above)
  );

  // Cell evaluation
  assign in_ready = !skid_valid_r;
  assign fire_in  = in_valid && in_ready;
  assign out_pop  = out_valid_r && out_ready;

  assign row_end = col_pos_r >= last_col_r;
  assign done    = row_end && (row_pos_r >= last_row_r);

  always_comb begin
    min_ul = (above < left_r) ? above : left_r;
    min3   = (diag_r < min_ul) ? diag_r : min_ul;
    inc    = {1'b0, min3} + (lesf_pkg::SIZE_W+1)'(1);
    if (!in_cell_empty) begin
      size = '0;
    end else if (row_pos_r == '0 || col_pos_r == '0) begin
      size = lesf_pkg::SIZE_W'(1);
    end else if (inc[lesf_pkg::SIZE_W]) begin
      size = '1;
    end else begin
      size = inc[lesf_pkg::SIZE_W-1:0];
    end

    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (size > best_size_r) begin
      best_size_nxt = size;
      best_row_nxt  = row_pos_r;
      best_col_nxt  = col_pos_r;
    end

    res.cell_size = size;
    res.map_done  = done;
    res.best_row  = done ? lesf_pkg::OUT_POS_W'(best_row_nxt) : '0;
    res.best_col  = done ? lesf_pkg::OUT_POS_W'(best_col_nxt) : '0;
    res.best_size = done ? best_size_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (fire_in) begin
      if (done) begin
        col_pos_r   <= '0;
        row_pos_r   <= '0;
        left_r      <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
        if (row_end) begin
          col_pos_r <= '0;
          row_pos_r <= row_pos_r + lesf_pkg::ROW_W'(1);
          left_r    <= '0;
          diag_r    <= '0;
        end else begin
          col_pos_r <= col_pos_r + lesf_pkg::COL_W'(1);
          left_r    <= size;
          diag_r    <= above;
        end
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (fire_in) begin
      if (out_valid_r && !out_pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (fire_in) begin
      if (out_valid_r && !out_pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_size = out_r.cell_size;
  assign out_map_done  = out_r.map_done;
  assign out_best_row  = out_r.best_row;
  assign out_best_col  = out_r.best_col;
  assign out_best_size = out_r.best_size;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_best_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.map_done |-> out_r.best_size == '0 && out_r.best_row == '0
      && out_r.best_col == '0)
    else $error("best fields set on a result that does not end the map");

  a_map_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire_in && done |=> col_pos_r == '0 && row_pos_r == '0 && best_size_r == '0)
    else $error("map state not cleared after the last cell");

  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fire_in && !row_end |=> col_pos_r == $past(col_pos_r) + lesf_pkg::COL_W'(1))
    else $error("column position did not advance within a row");

endmodule
